// File: hw/rtl/fths_pkg.sv
// shared types and constants for the frame tile splitter with tile hashes
`timescale 1ns / 1ps

package fths_pkg;

    localparam int TILE_WIDTH_DEF       = 80;
    localparam int TILE_HEIGHT_DEF      = 40;
    localparam int MAX_FRAME_WIDTH_DEF  = 800;
    localparam int MAX_FRAME_HEIGHT_DEF = 480;

    localparam int FRAME_WIDTH_RST  = 800;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam int FW_W       = 10;
    localparam int FH_W       = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // widest tile coordinates any legal tile size can produce
    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int TX_W  = 8;
    localparam int TY_W  = 8;
    localparam int ADD_W = FW_W + 4;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } pix_in_t;

    typedef struct packed {
        logic [6:0]      tile_index;
        logic [11:0]     pixel_offset;
        logic [7:0]      red_out;
        logic [7:0]      green_out;
        logic [7:0]      blue_out;
        logic [7:0]      alpha_out;
        logic [FW_W-1:0] tile_origin_x;
        logic [FH_W-1:0] tile_origin_y;
        logic            tile_done;
        logic [31:0]     tile_hash;
        logic            frame_done;
    } pix_out_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [TX_W-1:0]  tx;
        logic [TY_W-1:0]  ty;
        logic [FW_W-1:0]  origin_x;
        logic [FH_W-1:0]  origin_y;
        logic             tile_start;
        logic             tile_done;
        logic             frame_done;
        logic [ADD_W-1:0] add_term;
    } cmd_t;

endpackage

// File: hw/rtl/frame_tile_splitter_hash.sv
// top level: BGRA raster pixels in, RGBA pixels with tile position and tile hash out
// path: an accepted input beat is registered in the queue, then in the back end stage, then in the output register
// throughput: one pixel per cycle while m_ready holds, set by the hash read-add-write loop
// reset: raster counters to the frame origin, frame size 800 x 480, queue empty
// the per-column hash store is not cleared; each tile restarts its hash at its origin
`timescale 1ns / 1ps

module frame_tile_splitter_hash #(
    parameter int TILE_WIDTH       = fths_pkg::TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT      = fths_pkg::TILE_HEIGHT_DEF,
    parameter int MAX_FRAME_WIDTH  = fths_pkg::MAX_FRAME_WIDTH_DEF,
    parameter int MAX_FRAME_HEIGHT = fths_pkg::MAX_FRAME_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [fths_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fths_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fths_pkg::pix_in_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fths_pkg::pix_out_t               m_data
);

    localparam int W_LIM = (MAX_FRAME_WIDTH < 2**fths_pkg::FW_W - 1) ?
                           MAX_FRAME_WIDTH : 2**fths_pkg::FW_W - 1;
    localparam int H_LIM = (MAX_FRAME_HEIGHT < 2**fths_pkg::FH_W - 1) ?
                           MAX_FRAME_HEIGHT : 2**fths_pkg::FH_W - 1;
    localparam int MAX_TPR   = (W_LIM / TILE_WIDTH > 1) ? W_LIM / TILE_WIDTH : 1;
    localparam int MAX_TPC   = (H_LIM / TILE_HEIGHT > 1) ? H_LIM / TILE_HEIGHT : 1;
    localparam int TPR_W     = $clog2(MAX_TPR + 1);
    localparam int TPC_W     = $clog2(MAX_TPC + 1);
    localparam int ACC_DEPTH = MAX_TPR + 1;

    logic [TPR_W-1:0] tiles_per_row;
    logic [TPC_W-1:0] tiles_per_col;
    logic             q_wr_en, q_rd_en, q_full, q_empty;
    fths_pkg::cmd_t   q_wr_data, q_rd_data;

    fths_cfg #(
        .TILE_WIDTH       (TILE_WIDTH),
        .TILE_HEIGHT      (TILE_HEIGHT),
        .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
        .TPR_W            (TPR_W),
        .TPC_W            (TPC_W)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .tiles_per_row (tiles_per_row),
        .tiles_per_col (tiles_per_col)
    );

    fths_front #(
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT),
        .TPR_W       (TPR_W),
        .TPC_W       (TPC_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .tiles_per_row (tiles_per_row),
        .tiles_per_col (tiles_per_col),
        .q_full        (q_full),
        .q_wr_en       (q_wr_en),
        .q_wr_data     (q_wr_data)
    );

    fths_fifo #(
        .DEPTH (fths_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    fths_back #(
        .TILE_WIDTH (TILE_WIDTH),
        .TPR_W      (TPR_W),
        .ACC_DEPTH  (ACC_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_rd_data     (q_rd_data),
        .q_rd_en       (q_rd_en),
        .tiles_per_row (tiles_per_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

// File: hw/rtl/fths_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fths_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/fths_fifo.sv
// short command queue between the pixel front end and the hash back end
`timescale 1ns / 1ps

module fths_fifo #(
    parameter int DEPTH = fths_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  fths_pkg::cmd_t     wr_data,
    input  logic               rd_en,
    output fths_pkg::cmd_t     rd_data,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fths_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_read_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule

// File: hw/rtl/fths_cfg.sv
// frame size registers, kept as tiles per row and tile rows per frame
`timescale 1ns / 1ps

module fths_cfg #(
    parameter int TILE_WIDTH       = fths_pkg::TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT      = fths_pkg::TILE_HEIGHT_DEF,
    parameter int MAX_FRAME_WIDTH  = fths_pkg::MAX_FRAME_WIDTH_DEF,
    parameter int MAX_FRAME_HEIGHT = fths_pkg::MAX_FRAME_HEIGHT_DEF,
    parameter int TPR_W            = 4,
    parameter int TPC_W            = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fths_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fths_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [TPR_W-1:0]                  tiles_per_row,
    output logic [TPC_W-1:0]                  tiles_per_col
);

    localparam int FW_W = fths_pkg::FW_W;
    localparam int FH_W = fths_pkg::FH_W;

    localparam int W_LIM = (MAX_FRAME_WIDTH < 2**FW_W - 1) ? MAX_FRAME_WIDTH : 2**FW_W - 1;
    localparam int H_LIM = (MAX_FRAME_HEIGHT < 2**FH_W - 1) ? MAX_FRAME_HEIGHT : 2**FH_W - 1;

    // exact floor division by reciprocal multiply
    localparam int W_SHIFT = FW_W + $clog2(TILE_WIDTH);
    localparam int H_SHIFT = FH_W + $clog2(TILE_HEIGHT);
    localparam int W_RECIP = (2**W_SHIFT + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int H_RECIP = (2**H_SHIFT + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int W_PROD_W = FW_W + W_SHIFT + 1;
    localparam int H_PROD_W = FH_W + H_SHIFT + 1;

    localparam int W_RST_LIM = (fths_pkg::FRAME_WIDTH_RST < W_LIM) ?
                               fths_pkg::FRAME_WIDTH_RST : W_LIM;
    localparam int H_RST_LIM = (fths_pkg::FRAME_HEIGHT_RST < H_LIM) ?
                               fths_pkg::FRAME_HEIGHT_RST : H_LIM;
    localparam int TPR_RST = (W_RST_LIM / TILE_WIDTH > 1) ? W_RST_LIM / TILE_WIDTH : 1;
    localparam int TPC_RST = (H_RST_LIM / TILE_HEIGHT > 1) ? H_RST_LIM / TILE_HEIGHT : 1;

    logic [TPR_W-1:0]    tpr_reg, tpr_next;
    logic [TPC_W-1:0]    tpc_reg, tpc_next;
    logic [FW_W-1:0]     w_in, w_lim;
    logic [FH_W-1:0]     h_in, h_lim;
    logic [W_PROD_W-1:0] w_prod;
    logic [H_PROD_W-1:0] h_prod;
    logic [TPR_W-1:0]    w_tiles;
    logic [TPC_W-1:0]    h_tiles;

    always_comb begin
        w_in    = cfg_wdata[FW_W-1:0];
        h_in    = cfg_wdata[FH_W-1:0];
        w_lim   = (w_in > FW_W'(W_LIM)) ? FW_W'(W_LIM) : w_in;
        h_lim   = (h_in > FH_W'(H_LIM)) ? FH_W'(H_LIM) : h_in;
        w_prod  = W_PROD_W'(w_lim) * W_PROD_W'(W_RECIP);
        h_prod  = H_PROD_W'(h_lim) * H_PROD_W'(H_RECIP);
        w_tiles = w_prod[W_SHIFT +: TPR_W];
        h_tiles = h_prod[H_SHIFT +: TPC_W];
        if (w_tiles == '0) begin
            w_tiles = TPR_W'(1);
        end
        if (h_tiles == '0) begin
            h_tiles = TPC_W'(1);
        end
    end

    always_comb begin
        tpr_next = tpr_reg;
        tpc_next = tpc_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fths_pkg::REG_FRAME_WIDTH: begin
                    tpr_next = w_tiles;
                end
                fths_pkg::REG_FRAME_HEIGHT: begin
                    tpc_next = h_tiles;
                end
                default: begin
                    tpr_next = tpr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpr_reg <= TPR_W'(TPR_RST);
            tpc_reg <= TPC_W'(TPC_RST);
        end else begin
            tpr_reg <= tpr_next;
            tpc_reg <= tpc_next;
        end
    end

    assign tiles_per_row = tpr_reg;
    assign tiles_per_col = tpc_reg;

endmodule

// File: hw/rtl/fths_front.sv
// front end: raster counters, tile classification and hash increment per pixel
`timescale 1ns / 1ps

module fths_front #(
    parameter int TILE_WIDTH  = fths_pkg::TILE_WIDTH_DEF,
    parameter int TILE_HEIGHT = fths_pkg::TILE_HEIGHT_DEF,
    parameter int TPR_W       = 4,
    parameter int TPC_W       = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fths_pkg::pix_in_t    s_data,
    input  logic [TPR_W-1:0]     tiles_per_row,
    input  logic [TPC_W-1:0]     tiles_per_col,
    input  logic                 q_full,
    output logic                 q_wr_en,
    output fths_pkg::cmd_t       q_wr_data
);

    localparam int FW_W  = fths_pkg::FW_W;
    localparam int FH_W  = fths_pkg::FH_W;
    localparam int ADD_W = fths_pkg::ADD_W;
    localparam int TXC_W = $clog2(TILE_WIDTH);
    localparam int TYC_W = $clog2(TILE_HEIGHT);

    logic [FW_W-1:0]  x_reg, x_next, x_cur;
    logic [FH_W-1:0]  y_reg, y_next, y_cur;
    logic [TXC_W-1:0] tx_reg, tx_next, tx_cur;
    logic [TYC_W-1:0] ty_reg, ty_next, ty_cur;
    logic [TPR_W-1:0] col_reg, col_next, col_cur;
    logic [TPC_W-1:0] row_reg, row_next, row_cur;

    logic             fire;
    logic             last_tx, last_ty, last_col, last_row, eol;
    logic [9:0]       sum_px;
    logic [FW_W:0]    xy_sum;

    assign s_ready = !q_full;
    assign fire    = s_valid && !q_full;
    assign q_wr_en = fire;

    always_comb begin
        // counters left past the frame by a size change restart at zero
        x_cur   = x_reg;
        tx_cur  = tx_reg;
        col_cur = col_reg;
        y_cur   = y_reg;
        ty_cur  = ty_reg;
        row_cur = row_reg;
        if (col_reg >= tiles_per_row) begin
            x_cur   = '0;
            tx_cur  = '0;
            col_cur = '0;
        end
        if (row_reg >= tiles_per_col) begin
            y_cur   = '0;
            ty_cur  = '0;
            row_cur = '0;
        end

        last_tx  = (tx_cur == TXC_W'(TILE_WIDTH - 1));
        last_ty  = (ty_cur == TYC_W'(TILE_HEIGHT - 1));
        last_col = (col_cur == tiles_per_row - TPR_W'(1));
        last_row = (row_cur == tiles_per_col - TPC_W'(1));
        eol      = last_tx && last_col;

        tx_next  = tx_reg;
        col_next = col_reg;
        x_next   = x_reg;
        ty_next  = ty_reg;
        row_next = row_reg;
        y_next   = y_reg;
        if (fire) begin
            tx_next  = last_tx ? '0 : tx_cur + TXC_W'(1);
            col_next = last_tx ? (last_col ? '0 : col_cur + TPR_W'(1)) : col_cur;
            x_next   = eol ? '0 : x_cur + FW_W'(1);
            ty_next  = ty_cur;
            row_next = row_cur;
            y_next   = y_cur;
            if (eol) begin
                ty_next  = last_ty ? '0 : ty_cur + TYC_W'(1);
                row_next = last_ty ? (last_row ? '0 : row_cur + TPC_W'(1)) : row_cur;
                y_next   = (last_ty && last_row) ? '0 : y_cur + FH_W'(1);
            end
        end
    end

    always_comb begin
        sum_px = 10'(s_data.red) + 10'(s_data.green) + 10'(s_data.blue) + 10'(s_data.alpha);
        xy_sum = {1'b0, x_cur} + (FW_W + 1)'(y_cur);

        q_wr_data.red        = s_data.red;
        q_wr_data.green      = s_data.green;
        q_wr_data.blue       = s_data.blue;
        q_wr_data.alpha      = s_data.alpha;
        q_wr_data.col        = fths_pkg::COL_W'(col_cur);
        q_wr_data.row        = fths_pkg::ROW_W'(row_cur);
        q_wr_data.tx         = fths_pkg::TX_W'(tx_cur);
        q_wr_data.ty         = fths_pkg::TY_W'(ty_cur);
        q_wr_data.origin_x   = x_cur - FW_W'(tx_cur);
        q_wr_data.origin_y   = y_cur - FH_W'(ty_cur);
        q_wr_data.tile_start = (tx_cur == '0) && (ty_cur == '0);
        q_wr_data.tile_done  = last_tx && last_ty;
        q_wr_data.frame_done = eol && last_ty && last_row;
        q_wr_data.add_term   = ADD_W'(sum_px) + ADD_W'({xy_sum, 2'b00});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg   <= '0;
            y_reg   <= '0;
            tx_reg  <= '0;
            ty_reg  <= '0;
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && q_wr_data.frame_done |=> (x_reg == '0) && (y_reg == '0) &&
                                         (col_reg == '0) && (row_reg == '0))
        else $error("counters not at origin after frame end");

    a_start_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && q_wr_data.tile_start |-> !q_wr_data.tile_done)
        else $error("tile origin pixel flagged as tile end");

endmodule

// File: hw/rtl/fths_back.sv
// back end: per-column hash store, tile index and offset, output register
`timescale 1ns / 1ps

module fths_back #(
    parameter int TILE_WIDTH = fths_pkg::TILE_WIDTH_DEF,
    parameter int TPR_W      = 4,
    parameter int ACC_DEPTH  = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  fths_pkg::cmd_t       q_rd_data,
    output logic                 q_rd_en,
    input  logic [TPR_W-1:0]     tiles_per_row,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fths_pkg::pix_out_t   m_data
);

    localparam int ACC_AW     = $clog2(ACC_DEPTH);
    localparam int IDX_FULL_W = fths_pkg::ROW_W + TPR_W + 1;
    localparam int OFF_FULL_W = fths_pkg::TX_W + fths_pkg::TY_W + 1;

    logic                  a_valid_reg, a_valid_next;
    fths_pkg::cmd_t        a_reg;
    logic                  out_valid_reg, out_valid_next;
    fths_pkg::pix_out_t    out_reg, out_next;
    logic [ACC_AW-1:0]     last_slot_reg;
    logic [31:0]           last_hash_reg;

    logic                  out_free, a_move, a_load;
    logic [ACC_AW-1:0]     rd_slot, a_slot;
    logic [31:0]           acc_rdata, base, hash;
    logic [IDX_FULL_W-1:0] idx_full;
    logic [OFF_FULL_W-1:0] off_full;

    assign out_free = !out_valid_reg || m_ready;
    assign a_move   = a_valid_reg && out_free;
    assign a_load   = !q_empty && (!a_valid_reg || a_move);
    assign q_rd_en  = a_load;

    always_comb begin
        rd_slot = (32'(q_rd_data.col) >= ACC_DEPTH) ? ACC_AW'(ACC_DEPTH - 1)
                                                    : ACC_AW'(q_rd_data.col);
        a_slot  = (32'(a_reg.col) >= ACC_DEPTH) ? ACC_AW'(ACC_DEPTH - 1)
                                                : ACC_AW'(a_reg.col);
    end

    fths_ram #(
        .WIDTH (32),
        .DEPTH (ACC_DEPTH)
    ) u_acc (
        .aclk    (aclk),
        .wr_en   (a_move),
        .wr_addr (a_slot),
        .wr_data (hash),
        .rd_en   (a_load),
        .rd_addr (rd_slot),
        .rd_data (acc_rdata)
    );

    always_comb begin
        // the last write may land on the edge of this read, so take it directly
        if (a_reg.tile_start) begin
            base = '0;
        end else if (a_slot == last_slot_reg) begin
            base = last_hash_reg;
        end else begin
            base = acc_rdata;
        end
        hash = base + 32'(a_reg.add_term);

        idx_full = IDX_FULL_W'(a_reg.row) * IDX_FULL_W'(tiles_per_row)
                 + IDX_FULL_W'(a_reg.col);
        off_full = OFF_FULL_W'(a_reg.ty) * OFF_FULL_W'(TILE_WIDTH)
                 + OFF_FULL_W'(a_reg.tx);
    end

    always_comb begin
        a_valid_next   = a_valid_reg;
        out_valid_next = out_valid_reg;
        if (a_load) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
        if (a_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_next.tile_index    = idx_full[6:0];
        out_next.pixel_offset  = off_full[11:0];
        out_next.red_out       = a_reg.red;
        out_next.green_out     = a_reg.green;
        out_next.blue_out      = a_reg.blue;
        out_next.alpha_out     = a_reg.alpha;
        out_next.tile_origin_x = a_reg.origin_x;
        out_next.tile_origin_y = a_reg.origin_y;
        out_next.tile_done     = a_reg.tile_done;
        out_next.tile_hash     = hash;
        out_next.frame_done    = a_reg.frame_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_reg <= q_rd_data;
        end
        if (a_move) begin
            out_reg       <= out_next;
            last_slot_reg <= a_slot;
            last_hash_reg <= hash;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_frame_ends_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.frame_done |-> out_reg.tile_done)
        else $error("frame end without tile end");

endmodule
